// ===== sv/cie_pkg.sv =====
package cie_pkg;

    // candidate buffer size
    localparam int TOKEN_MAX = 64;
    localparam int LEN_W     = $clog2(TOKEN_MAX + 1);
    localparam int ADDR_W    = $clog2(TOKEN_MAX);

    // header format register codes
    localparam logic [1:0] FMT_PLAIN = 2'd0;
    localparam logic [1:0] FMT_LIST  = 2'd1;
    localparam logic [1:0] FMT_FWD   = 2'd2;
    localparam logic [1:0] FMT_VIA   = 2'd3;

    // characters
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_LBR   = 8'h5B;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_RBR   = 8'h5D;
    localparam logic [7:0] CH_F_UC  = 8'h46;
    localparam logic [7:0] CH_F_LC  = 8'h66;
    localparam logic [7:0] CH_O_UC  = 8'h4F;
    localparam logic [7:0] CH_O_LC  = 8'h6F;
    localparam logic [7:0] CH_R_UC  = 8'h52;
    localparam logic [7:0] CH_R_LC  = 8'h72;

    // private ranges
    localparam logic [31:0] V4_NET10   = 32'h0A000000;
    localparam logic [31:0] V4_NET172  = 32'hAC100000;
    localparam logic [31:0] V4_NET192  = 32'hC0A80000;
    localparam logic [31:0] V4_NET127  = 32'h7F000000;
    localparam logic [31:0] V4_NET169  = 32'hA9FE0000;
    localparam logic [31:0] V4_MASK8   = 32'hFF000000;
    localparam logic [31:0] V4_MASK12  = 32'hFFF00000;
    localparam logic [31:0] V4_MASK16  = 32'hFFFF0000;
    localparam logic [7:0]  V6_FE      = 8'hFE;
    localparam logic [7:0]  V6_FD      = 8'hFD;
    localparam logic [7:0]  V6_FC      = 8'hFC;
    localparam logic [7:0]  V6_SITE_M  = 8'hC0;
    localparam logic [15:0] V6_MAPPED  = 16'hFFFF;

    // controller to datapath
    typedef struct packed {
        logic in_take;
        logic cfg_take;
        logic decide;
        logic scan_use;
        logic setup;
        logic parse_use;
        logic fin1;
        logic fin2;
        logic abort;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic ev_pend;
        logic ev_port;
        logic ev_skip;
        logic last_pend;
        logic scan_last;
        logic br_fail;
        logic p_empty;
        logic p_last;
        logic out_free;
    } t_sts;

    // dotted quad parser state
    typedef struct packed {
        logic        fail;
        logic        saw;
        logic [2:0]  oct;
        logic [7:0]  cur;
        logic [31:0] q;
    } t_v4;

    localparam t_v4 V4_INIT = '{fail: 1'b0, saw: 1'b0, oct: 3'd0, cur: 8'd0, q: 32'd0};

    // ipv6 group collector: groups before the gap and after it
    typedef struct packed {
        logic [127:0] head;
        logic [127:0] tl;
        logic [3:0]   cnt;
    } t_v6acc;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        if (is_digit(c)) begin
            v = c[3:0];
        end else begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

    // one character of inet_pton dotted quad
    function automatic t_v4 v4_step(input t_v4 s, input logic [7:0] c);
        t_v4         r;
        logic [11:0] nc;
        logic [2:0]  no;
        r  = s;
        nc = ({4'd0, s.cur} << 3) + ({4'd0, s.cur} << 1) + {8'd0, c[3:0]};
        no = s.oct;
        if (!s.fail) begin
            if (is_digit(c)) begin
                if (s.saw && (s.cur == 8'd0)) begin
                    r.fail = 1'b1;
                end else if (nc > 12'd255) begin
                    r.fail = 1'b1;
                end else begin
                    if (!s.saw) begin
                        if (s.oct == 3'd4) begin
                            r.fail = 1'b1;
                        end
                        no    = s.oct + 3'd1;
                        r.oct = no;
                        r.saw = 1'b1;
                    end
                    r.cur = nc[7:0];
                    for (int k = 0; k < 4; k++) begin
                        if (no == 3'(k + 1)) begin
                            r.q[31 - 8 * k -: 8] = nc[7:0];
                        end
                    end
                end
            end else if ((c == CH_DOT) && s.saw) begin
                if (s.oct == 3'd4) begin
                    r.fail = 1'b1;
                end else begin
                    r.cur = 8'd0;
                    r.saw = 1'b0;
                end
            end else begin
                r.fail = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic v4_ok(input t_v4 s);
        return !s.fail && (s.oct == 3'd4);
    endfunction

    // append one 16-bit group
    function automatic t_v6acc acc_push(input t_v6acc a, input logic gap, input logic [15:0] v);
        t_v6acc r;
        r = a;
        if (gap) begin
            r.tl = {a.tl[111:0], v};
        end else begin
            for (int k = 0; k < 8; k++) begin
                if (a.cnt[2:0] == 3'(k)) begin
                    r.head[127 - 16 * k -: 16] = v;
                end
            end
        end
        r.cnt = a.cnt + 4'd1;
        return r;
    endfunction

endpackage

// ===== sv/cie_if.sv =====
interface cie_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] header_byte;
    logic       last_byte;

    modport source (output valid, output header_byte, output last_byte, input ready);
    modport sink   (input valid, input header_byte, input last_byte, output ready);
endinterface

interface cie_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic        is_ipv6;
    logic [63:0] address_high;
    logic [63:0] address_low;

    modport source (output valid, output found, output is_ipv6, output address_high,
                    output address_low, input ready);
    modport sink   (input valid, input found, input is_ipv6, input address_high,
                    input address_low, output ready);
endinterface

interface cie_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] header_format;

    modport source (output valid, output header_format, input ready);
    modport sink   (input valid, input header_format, output ready);
endinterface

// ===== sv/client_ip_header_extractor.sv =====
// channel   dir  transfer when        payload
// i_in      in   valid && ready      header_byte[7:0], last_byte
// o_out     out  valid && ready      found, is_ipv6, address_high[63:0], address_low[63:0]
// i_cfg     in   valid && ready      header_format[1:0]
//
// each byte passes through the decide state; a byte that ends a candidate walks the buffer
// through the read and use states (a bracket and port scan first, then the parse, for all formats
// but plain) and finishes the check in the fin1 and fin2 states, all through the single read port
// of the candidate buffer; the last byte of a header value then loads the output register
// once it is free; synchronous reset needs no clearing pass; the output register holds a result
// until taken and a new byte is still accepted meanwhile
module client_ip_header_extractor (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cie_in_if.sink    i_in,
    cie_out_if.source o_out,
    cie_cfg_if.sink   i_cfg
);

    cie_pkg::t_cmd w_cmd;
    cie_pkg::t_sts w_sts;

    // sequencer
    cie_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_cfg_valid (i_cfg.valid),
        .i_sts       (w_sts),
        .o_in_ready  (i_in.ready),
        .o_cfg_ready (i_cfg.ready),
        .o_cmd       (w_cmd)
    );

    // splitter, buffer, parsers and result
    cie_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_header_byte   (i_in.header_byte),
        .i_last_byte     (i_in.last_byte),
        .i_header_format (i_cfg.header_format),
        .i_out_ready     (o_out.ready),
        .o_valid         (o_out.valid),
        .o_found         (o_out.found),
        .o_is_ipv6       (o_out.is_ipv6),
        .o_address_high  (o_out.address_high),
        .o_address_low   (o_out.address_low)
    );

endmodule

// ===== sv/cie_ctl.sv =====
module cie_ctl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_cfg_valid,
    input  cie_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output logic          o_cfg_ready,
    output cie_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN_RD,
        S_SCAN_USE,
        S_SETUP,
        S_PARSE_RD,
        S_PARSE_USE,
        S_FIN1,
        S_FIN2,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    t_state w_post;

    // after a candidate: report if the byte was the last one
    assign w_post = i_sts.last_pend ? S_DONE : S_IDLE;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_cfg_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_cfg_ready    = 1'b1;
                o_in_ready     = !i_cfg_valid;
                o_cmd.cfg_take = i_cfg_valid;
                if (i_in_valid && !i_cfg_valid) begin
                    o_cmd.in_take = 1'b1;
                    n_state       = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                if (!i_sts.ev_pend) begin
                    n_state = w_post;
                end else if (i_sts.ev_skip) begin
                    o_cmd.abort = 1'b1;
                    n_state     = w_post;
                end else if (i_sts.ev_port) begin
                    n_state = S_SCAN_RD;
                end else begin
                    n_state = S_SETUP;
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_USE;
            end
            S_SCAN_USE: begin
                o_cmd.scan_use = 1'b1;
                n_state        = i_sts.scan_last ? S_SETUP : S_SCAN_RD;
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                if (i_sts.br_fail) begin
                    o_cmd.abort = 1'b1;
                    n_state     = w_post;
                end else if (i_sts.p_empty) begin
                    n_state = S_FIN1;
                end else begin
                    n_state = S_PARSE_RD;
                end
            end
            S_PARSE_RD: begin
                n_state = S_PARSE_USE;
            end
            S_PARSE_USE: begin
                o_cmd.parse_use = 1'b1;
                n_state         = i_sts.p_last ? S_FIN1 : S_PARSE_RD;
            end
            S_FIN1: begin
                o_cmd.fin1 = 1'b1;
                n_state    = S_FIN2;
            end
            S_FIN2: begin
                o_cmd.fin2 = 1'b1;
                n_state    = w_post;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== sv/cie_dp.sv =====
module cie_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cie_pkg::t_cmd i_cmd,
    output cie_pkg::t_sts o_sts,
    input  logic [7:0]    i_header_byte,
    input  logic          i_last_byte,
    input  logic [1:0]    i_header_format,
    input  logic          i_out_ready,
    output logic          o_valid,
    output logic          o_found,
    output logic          o_is_ipv6,
    output logic [63:0]   o_address_high,
    output logic [63:0]   o_address_low
);

    localparam int LW = cie_pkg::LEN_W;
    localparam int AW = cie_pkg::ADDR_W;

    // element phases, per format
    localparam logic [2:0] LIST_LEAD   = 3'd0;
    localparam logic [2:0] LIST_BODY   = 3'd1;
    localparam logic [2:0] FWD_ELEM    = 3'd0;
    localparam logic [2:0] FWD_KEY     = 3'd1;
    localparam logic [2:0] FWD_VSTART  = 3'd2;
    localparam logic [2:0] FWD_TOKEN   = 3'd3;
    localparam logic [2:0] FWD_QUOTED  = 3'd4;
    localparam logic [2:0] VIA_START   = 3'd0;
    localparam logic [2:0] VIA_PROTO   = 3'd1;
    localparam logic [2:0] VIA_GAP     = 3'd2;
    localparam logic [2:0] VIA_HOST    = 3'd3;
    localparam logic [2:0] VIA_REST    = 3'd4;

    // key match progress for "for"
    localparam logic [2:0] KM_NONE = 3'd0;
    localparam logic [2:0] KM_F    = 3'd1;
    localparam logic [2:0] KM_FO   = 3'd2;
    localparam logic [2:0] KM_FOR  = 3'd3;
    localparam logic [2:0] KM_BAD  = 3'd4;

    logic [1:0]    r_fmt;
    logic [2:0]    r_phase, n_phase;
    logic [2:0]    r_key, n_key;
    logic          r_kif, n_kif;
    logic          r_esc, n_esc;
    logic          a_clr, a_push, a_eval, a_port;

    logic [7:0]    r_buf [cie_pkg::TOKEN_MAX];
    logic [7:0]    r_rd;
    logic [LW-1:0] r_len, n_len_base;
    logic          r_ovf, n_ovf_base;
    logic          w_we;

    logic          r_ev_pend, r_ev_port, r_last_pend;
    logic [LW-1:0] r_ptr, r_start, r_end;
    logic          r_b0_open, r_cl_found;
    logic [LW-1:0] r_cl_idx, r_first;
    logic [1:0]    r_colons;
    logic [LW-1:0] s_start, s_end;
    logic          s_br_fail;

    cie_pkg::t_v4    r_v4, r_e4, n_e4;
    cie_pkg::t_v6acc r_acc, n_acc, f_acc;
    logic            r_fail6, n_fail6, f_fail6;
    logic            r_tail, n_tail;
    logic            r_lead, n_lead;
    logic            r_gap, n_gap;
    logic [2:0]      r_dig, n_dig;
    logic [15:0]     r_val, n_val;
    logic            p_pos0, p_pos1, p_last;

    logic [127:0]  r_addr, f_addr;
    logic          r_aok, r_av6;
    logic [127:0]  c_addr;
    logic          c_v6, c_priv;

    logic          r_found, r_isv6;
    logic [63:0]   r_upper, r_lower;
    logic          r_o_valid;

    logic [7:0]    c;
    logic          c_sep, c_ws;

    assign c     = i_header_byte;
    assign c_sep = (c == cie_pkg::CH_SPACE) || (c == cie_pkg::CH_SEMI) || (c == cie_pkg::CH_COMMA);
    assign c_ws  = (c == cie_pkg::CH_SPACE) || (c == cie_pkg::CH_TAB);

    // element splitter: phase update and buffer actions for one byte
    always_comb begin
        n_phase = r_phase;
        n_key   = r_key;
        n_kif   = r_kif;
        n_esc   = r_esc;
        a_clr   = 1'b0;
        a_push  = 1'b0;
        a_eval  = 1'b0;
        a_port  = 1'b1;
        unique case (r_fmt)
            cie_pkg::FMT_PLAIN: begin
                a_push = 1'b1;
                a_eval = i_last_byte;
                a_port = 1'b0;
            end
            cie_pkg::FMT_LIST: begin
                if (c == cie_pkg::CH_COMMA) begin
                    a_eval  = 1'b1;
                    n_phase = LIST_LEAD;
                end else if (!((r_phase == LIST_LEAD) && (c == cie_pkg::CH_SPACE))) begin
                    n_phase = LIST_BODY;
                    a_push  = 1'b1;
                    a_eval  = i_last_byte;
                end
            end
            cie_pkg::FMT_FWD: begin
                case (r_phase)
                    FWD_ELEM: begin
                        if (!c_sep) begin
                            n_phase = FWD_KEY;
                            n_key   = ((c == cie_pkg::CH_F_LC) || (c == cie_pkg::CH_F_UC))
                                      ? KM_F : KM_BAD;
                        end
                    end
                    FWD_KEY: begin
                        if (c == cie_pkg::CH_EQ) begin
                            n_kif   = (r_key == KM_FOR);
                            n_phase = FWD_VSTART;
                        end else if ((r_key == KM_F) &&
                                     ((c == cie_pkg::CH_O_LC) || (c == cie_pkg::CH_O_UC))) begin
                            n_key = KM_FO;
                        end else if ((r_key == KM_FO) &&
                                     ((c == cie_pkg::CH_R_LC) || (c == cie_pkg::CH_R_UC))) begin
                            n_key = KM_FOR;
                        end else begin
                            n_key = KM_BAD;
                        end
                    end
                    FWD_VSTART: begin
                        a_clr = 1'b1;
                        if (c == cie_pkg::CH_QUOTE) begin
                            n_esc   = 1'b0;
                            n_phase = FWD_QUOTED;
                        end else if (c_sep) begin
                            n_phase = FWD_ELEM;
                        end else begin
                            a_push  = 1'b1;
                            n_phase = FWD_TOKEN;
                            a_eval  = i_last_byte && r_kif;
                        end
                    end
                    FWD_TOKEN: begin
                        if (c_sep) begin
                            a_eval  = r_kif;
                            n_phase = FWD_ELEM;
                        end else begin
                            a_push = 1'b1;
                            a_eval = i_last_byte && r_kif;
                        end
                    end
                    default: begin
                        if (r_esc) begin
                            a_push = 1'b1;
                            n_esc  = 1'b0;
                        end else if (c == cie_pkg::CH_QUOTE) begin
                            a_eval  = r_kif;
                            n_phase = FWD_ELEM;
                        end else begin
                            a_push = 1'b1;
                            n_esc  = (c == cie_pkg::CH_BSL);
                        end
                    end
                endcase
            end
            default: begin
                if (c == cie_pkg::CH_COMMA) begin
                    a_eval  = (r_phase == VIA_HOST);
                    a_clr   = (r_phase != VIA_HOST);
                    n_phase = VIA_START;
                end else begin
                    if (c_ws) begin
                        if (r_phase == VIA_PROTO) begin
                            n_phase = VIA_GAP;
                        end else if (r_phase == VIA_HOST) begin
                            a_eval  = 1'b1;
                            n_phase = VIA_REST;
                        end
                    end else begin
                        if (r_phase == VIA_START) begin
                            n_phase = VIA_PROTO;
                        end else if (r_phase == VIA_GAP) begin
                            a_clr   = 1'b1;
                            a_push  = 1'b1;
                            n_phase = VIA_HOST;
                        end else if (r_phase == VIA_HOST) begin
                            a_push = 1'b1;
                        end
                    end
                    if (i_last_byte && (n_phase == VIA_HOST)) begin
                        a_eval = 1'b1;
                    end
                end
            end
        endcase
    end

    // buffer write position
    assign n_len_base = a_clr ? '0 : r_len;
    assign n_ovf_base = a_clr ? 1'b0 : r_ovf;
    assign w_we = i_cmd.in_take && a_push && (n_len_base < LW'(cie_pkg::TOKEN_MAX));

    // candidate buffer, registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_buf[n_len_base[AW-1:0]] <= i_header_byte;
        end
        r_rd <= r_buf[r_ptr[AW-1:0]];
    end

    // address range after brackets or port
    always_comb begin
        s_br_fail = 1'b0;
        s_start   = '0;
        s_end     = r_len;
        if (r_ev_port && r_b0_open) begin
            s_br_fail = !r_cl_found;
            s_start   = LW'(1);
            s_end     = r_cl_idx;
        end else if (r_ev_port && (r_colons == 2'd1)) begin
            s_end = r_first;
        end
    end

    assign p_pos0 = (r_ptr == r_start);
    assign p_pos1 = (r_ptr == r_start + LW'(1));
    assign p_last = (r_ptr + LW'(1) == r_end);

    // ipv6 parser step on the read character
    always_comb begin
        n_fail6 = r_fail6;
        n_tail  = r_tail;
        n_lead  = r_lead;
        n_gap   = r_gap;
        n_dig   = r_dig;
        n_val   = r_val;
        n_acc   = r_acc;
        n_e4    = (r_rd == cie_pkg::CH_COLON) ? cie_pkg::V4_INIT : cie_pkg::v4_step(r_e4, r_rd);
        if (!r_fail6 && !r_tail) begin
            if (p_pos0 && (r_rd == cie_pkg::CH_COLON)) begin
                n_lead = 1'b1;
                if (p_last) begin
                    n_fail6 = 1'b1;
                end
            end else if (p_pos1 && r_lead && (r_rd != cie_pkg::CH_COLON)) begin
                n_fail6 = 1'b1;
            end else if (cie_pkg::is_hex(r_rd)) begin
                if (r_dig == 3'd4) begin
                    n_fail6 = 1'b1;
                end else begin
                    n_dig = r_dig + 3'd1;
                    n_val = {r_val[11:0], cie_pkg::hex_val(r_rd)};
                end
            end else if (r_rd == cie_pkg::CH_COLON) begin
                if (r_dig == 3'd0) begin
                    if (r_gap) begin
                        n_fail6 = 1'b1;
                    end else begin
                        n_gap = 1'b1;
                    end
                end else if (p_last || (r_acc.cnt == 4'd8)) begin
                    n_fail6 = 1'b1;
                end else begin
                    n_acc = cie_pkg::acc_push(r_acc, r_gap, r_val);
                    n_dig = 3'd0;
                    n_val = 16'd0;
                end
            end else if (r_rd == cie_pkg::CH_DOT) begin
                if (r_acc.cnt > 4'd6) begin
                    n_fail6 = 1'b1;
                end else begin
                    n_tail = 1'b1;
                end
            end else begin
                n_fail6 = 1'b1;
            end
        end
    end

    // ipv6 completion: last group, embedded quad, gap placement
    always_comb begin
        f_acc   = r_acc;
        f_fail6 = r_fail6;
        if (r_tail) begin
            f_fail6 = r_fail6 || !cie_pkg::v4_ok(r_e4);
            f_acc   = cie_pkg::acc_push(f_acc, r_gap, r_e4.q[31:16]);
            f_acc   = cie_pkg::acc_push(f_acc, r_gap, r_e4.q[15:0]);
        end else if (r_dig != 3'd0) begin
            if (r_acc.cnt == 4'd8) begin
                f_fail6 = 1'b1;
            end else begin
                f_acc = cie_pkg::acc_push(f_acc, r_gap, r_val);
            end
        end
        if (r_gap) begin
            if (f_acc.cnt == 4'd8) begin
                f_fail6 = 1'b1;
            end
            f_addr = f_acc.head | f_acc.tl;
        end else begin
            if (f_acc.cnt != 4'd8) begin
                f_fail6 = 1'b1;
            end
            f_addr = f_acc.head;
        end
    end

    // mapped address folding and private range check
    always_comb begin
        c_addr = r_addr;
        c_v6   = r_av6;
        if (r_av6 && (r_addr[127:48] == 80'd0) && (r_addr[47:32] == cie_pkg::V6_MAPPED)) begin
            c_v6          = 1'b0;
            c_addr[47:32] = 16'd0;
        end
        if (!c_v6) begin
            c_priv = ((c_addr[31:0] & cie_pkg::V4_MASK8)  == cie_pkg::V4_NET10)  ||
                     ((c_addr[31:0] & cie_pkg::V4_MASK12) == cie_pkg::V4_NET172) ||
                     ((c_addr[31:0] & cie_pkg::V4_MASK16) == cie_pkg::V4_NET192) ||
                     ((c_addr[31:0] & cie_pkg::V4_MASK8)  == cie_pkg::V4_NET127) ||
                     ((c_addr[31:0] & cie_pkg::V4_MASK16) == cie_pkg::V4_NET169);
        end else begin
            c_priv = ((c_addr[127:8] == 120'd0) && (c_addr[7:0] == 8'd1)) ||
                     ((c_addr[127:120] == cie_pkg::V6_FE) &&
                      ((c_addr[119:112] & cie_pkg::V6_SITE_M) == 8'h80)) ||
                     ((c_addr[127:120] == cie_pkg::V6_FE) &&
                      ((c_addr[119:112] & cie_pkg::V6_SITE_M) == cie_pkg::V6_SITE_M)) ||
                     (c_addr[127:120] == cie_pkg::V6_FD) ||
                     ((c_addr[127:120] & cie_pkg::V6_FE) == cie_pkg::V6_FC);
        end
    end

    // control and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt       <= cie_pkg::FMT_PLAIN;
            r_phase     <= '0;
            r_key       <= KM_NONE;
            r_kif       <= 1'b0;
            r_esc       <= 1'b0;
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_ev_pend   <= 1'b0;
            r_ev_port   <= 1'b0;
            r_last_pend <= 1'b0;
            r_found     <= 1'b0;
            r_isv6      <= 1'b0;
            r_upper     <= '0;
            r_lower     <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            // register write restarts the header value
            if (i_cmd.cfg_take) begin
                r_fmt   <= i_header_format;
                r_phase <= '0;
                r_key   <= KM_NONE;
                r_kif   <= 1'b0;
                r_esc   <= 1'b0;
                r_len   <= '0;
                r_ovf   <= 1'b0;
                r_found <= 1'b0;
                r_isv6  <= 1'b0;
                r_upper <= '0;
                r_lower <= '0;
            end
            // byte transfer
            if (i_cmd.in_take) begin
                r_ev_pend   <= a_eval;
                r_ev_port   <= a_port;
                r_last_pend <= i_last_byte;
                if (i_last_byte) begin
                    r_phase <= '0;
                    r_key   <= KM_NONE;
                    r_kif   <= 1'b0;
                    r_esc   <= 1'b0;
                end else begin
                    r_phase <= n_phase;
                    r_key   <= n_key;
                    r_kif   <= n_kif;
                    r_esc   <= n_esc;
                end
                r_len <= n_len_base;
                r_ovf <= n_ovf_base;
                if (a_push) begin
                    if (w_we) begin
                        r_len <= n_len_base + LW'(1);
                    end else begin
                        r_ovf <= 1'b1;
                    end
                end
            end
            // keep the first public address
            if (i_cmd.fin2 && r_aok && !c_priv) begin
                r_found <= 1'b1;
                r_isv6  <= c_v6;
                r_upper <= c_addr[127:64];
                r_lower <= c_addr[63:0];
            end
            if (i_cmd.fin2 || i_cmd.abort) begin
                r_len <= '0;
                r_ovf <= 1'b0;
            end
            // result out and restart
            if (i_cmd.out_load) begin
                r_o_valid <= 1'b1;
                r_found   <= 1'b0;
                r_isv6    <= 1'b0;
                r_upper   <= '0;
                r_lower   <= '0;
                r_len     <= '0;
                r_ovf     <= 1'b0;
            end else if (r_o_valid && i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // walk and parser registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_ptr      <= '0;
            r_b0_open  <= 1'b0;
            r_cl_found <= 1'b0;
            r_colons   <= 2'd0;
        end
        // first walk: brackets and colons
        if (i_cmd.scan_use) begin
            r_ptr <= r_ptr + LW'(1);
            if (r_ptr == '0) begin
                r_b0_open <= (r_rd == cie_pkg::CH_LBR);
            end
            if ((r_ptr != '0) && (r_rd == cie_pkg::CH_RBR) && !r_cl_found) begin
                r_cl_found <= 1'b1;
                r_cl_idx   <= r_ptr;
            end
            if (r_rd == cie_pkg::CH_COLON) begin
                if (r_colons == 2'd0) begin
                    r_first <= r_ptr;
                end
                if (r_colons != 2'd2) begin
                    r_colons <= r_colons + 2'd1;
                end
            end
        end
        if (i_cmd.setup) begin
            r_start <= s_start;
            r_end   <= s_end;
            r_ptr   <= s_start;
            r_v4    <= cie_pkg::V4_INIT;
            r_e4    <= cie_pkg::V4_INIT;
            r_acc   <= '0;
            r_fail6 <= 1'b0;
            r_tail  <= 1'b0;
            r_lead  <= 1'b0;
            r_gap   <= 1'b0;
            r_dig   <= 3'd0;
            r_val   <= 16'd0;
        end
        // second walk: both parsers
        if (i_cmd.parse_use) begin
            r_ptr   <= r_ptr + LW'(1);
            r_v4    <= cie_pkg::v4_step(r_v4, r_rd);
            r_e4    <= n_e4;
            r_acc   <= n_acc;
            r_fail6 <= n_fail6;
            r_tail  <= n_tail;
            r_lead  <= n_lead;
            r_gap   <= n_gap;
            r_dig   <= n_dig;
            r_val   <= n_val;
        end
        if (i_cmd.fin1) begin
            r_aok  <= cie_pkg::v4_ok(r_v4) || !f_fail6;
            r_av6  <= !cie_pkg::v4_ok(r_v4);
            r_addr <= cie_pkg::v4_ok(r_v4) ? {96'd0, r_v4.q} : f_addr;
        end
        if (i_cmd.out_load) begin
            o_found        <= r_found;
            o_is_ipv6      <= r_found && r_isv6;
            o_address_high <= r_found ? r_upper : 64'd0;
            o_address_low  <= r_found ? r_lower : 64'd0;
        end
    end

    assign o_valid = r_o_valid;

    // status to the controller
    assign o_sts.ev_pend   = r_ev_pend;
    assign o_sts.ev_port   = r_ev_port;
    assign o_sts.ev_skip   = r_found || r_ovf || (r_len == '0);
    assign o_sts.last_pend = r_last_pend;
    assign o_sts.scan_last = (r_ptr + LW'(1) == r_len);
    assign o_sts.br_fail   = s_br_fail;
    assign o_sts.p_empty   = (s_end == s_start);
    assign o_sts.p_last    = p_last;
    assign o_sts.out_free  = !r_o_valid || i_out_ready;

endmodule
